>>> src/signed_int_to_decimal_ascii_macros.svh
// Assertion macros shared by the signed_int_to_decimal_ascii RTL.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SITDA_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SITDA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/sitda_pkg.sv
// Package for the signed integer to decimal ASCII converter.
// Holds the microcode word format, status bundle and character constants.
package sitda_pkg;

	localparam int unsigned STEP_W = 3;

	typedef logic [STEP_W-1:0] step_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_LOAD,
		OP_SHIFT,
		OP_SKIP,
		OP_SIGN,
		OP_DIGIT
	} op_t;

	typedef enum logic [2:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_NO_INPUT,
		COND_BITS_LEFT,
		COND_LEAD_ZERO,
		COND_MORE_DIGITS
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} ctrl_word_t;

	typedef struct packed {
		logic out_free;
		logic negative;
		logic bits_left;
		logic lead_zero;
		logic more_digits;
	} status_t;

	localparam logic [7:0] CHAR_ZERO  = 8'd48;
	localparam logic [7:0] CHAR_NINE  = 8'd57;
	localparam logic [7:0] CHAR_MINUS = 8'd45;

	localparam logic [3:0] DIGIT_ADJ_MIN = 4'd5;
	localparam logic [3:0] DIGIT_ADJ_ADD = 4'd3;

	localparam step_t STEP_LOAD  = 3'd0;
	localparam step_t STEP_SHIFT = 3'd1;
	localparam step_t STEP_SKIP  = 3'd2;
	localparam step_t STEP_SIGN  = 3'd3;
	localparam step_t STEP_DIGIT = 3'd4;
	localparam step_t STEP_DONE  = 3'd5;

endpackage

>>> src/sitda_ucode_rom.sv
// Microcode ROM: one control word for each program step.
// Depends on sitda_pkg for the control word format and step names.
module sitda_ucode_rom (
	input  sitda_pkg::step_t      step,
	output sitda_pkg::ctrl_word_t ctrl
);
	import sitda_pkg::*;

	always_comb begin
		unique case (step)
			STEP_LOAD:  ctrl = '{op: OP_LOAD,  cond: COND_NO_INPUT,    target: STEP_LOAD};
			STEP_SHIFT: ctrl = '{op: OP_SHIFT, cond: COND_BITS_LEFT,   target: STEP_SHIFT};
			STEP_SKIP:  ctrl = '{op: OP_SKIP,  cond: COND_LEAD_ZERO,   target: STEP_SKIP};
			STEP_SIGN:  ctrl = '{op: OP_SIGN,  cond: COND_NEVER,       target: STEP_LOAD};
			STEP_DIGIT: ctrl = '{op: OP_DIGIT, cond: COND_MORE_DIGITS, target: STEP_DIGIT};
			STEP_DONE:  ctrl = '{op: OP_NOP,   cond: COND_ALWAYS,      target: STEP_LOAD};
			default:    ctrl = '{op: OP_NOP,   cond: COND_ALWAYS,      target: STEP_LOAD};
		endcase
	end

endmodule

>>> src/sitda_sequencer.sv
// Step counter with conditional jumps and output-stall hold.
// Depends on sitda_pkg for the control word and status bundle.
module sitda_sequencer (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  sitda_pkg::ctrl_word_t ctrl,
	input  sitda_pkg::status_t    status,
	output sitda_pkg::step_t      step
);
	import sitda_pkg::*;

	step_t step_q;
	step_t step_d;
	logic  cond_true;
	logic  hold;

	always_comb begin
		unique case (ctrl.cond)
			COND_NEVER:       cond_true = 1'b0;
			COND_ALWAYS:      cond_true = 1'b1;
			COND_NO_INPUT:    cond_true = !in_valid;
			COND_BITS_LEFT:   cond_true = status.bits_left;
			COND_LEAD_ZERO:   cond_true = status.lead_zero;
			COND_MORE_DIGITS: cond_true = status.more_digits;
			default:          cond_true = 1'b0;
		endcase
	end

	// A step that writes a character waits while the output register is occupied.
	assign hold = !status.out_free &&
		((ctrl.op == OP_DIGIT) || ((ctrl.op == OP_SIGN) && status.negative));

	always_comb begin
		if (hold) begin
			step_d = step_q;
		end else if (cond_true) begin
			step_d = ctrl.target;
		end else begin
			step_d = step_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_LOAD;
		end else begin
			step_q <= step_d;
		end
	end

	assign step = step_q;

endmodule

>>> src/sitda_datapath.sv
// Datapath: magnitude shifter, BCD double-dabble register and output register.
// Depends on sitda_pkg and on signed_int_to_decimal_ascii_macros.svh.
`include "signed_int_to_decimal_ascii_macros.svh"
module sitda_datapath #(
	parameter int VB = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sitda_pkg::ctrl_word_t ctrl,
	input  logic                  in_valid,
	input  logic signed [VB-1:0]  value,
	input  logic                  out_ready,
	output sitda_pkg::status_t    status,
	output logic                  out_valid,
	output logic [7:0]            char_code,
	output logic                  last
);
	import sitda_pkg::*;

	localparam int NDIG  = ((VB - 1) * 30103) / 100000 + 1;
	localparam int BCD_W = NDIG * 4;
	localparam int BCW   = $clog2(VB);
	localparam int DCW   = $clog2(NDIG + 1);

	logic [VB-1:0]    val_u;
	logic [VB-1:0]    mag_in;
	logic [VB-1:0]    mag_q;
	logic [BCD_W-1:0] bcd_q;
	logic [BCD_W-1:0] adj;
	logic [BCW-1:0]   bit_cnt_q;
	logic [DCW-1:0]   dig_cnt_q;
	logic             neg_q;
	logic [3:0]       top_digit;
	logic             out_free;
	logic             lead_zero;
	logic             emit;
	logic             out_valid_q;
	logic [7:0]       char_code_q;
	logic             last_q;

	assign val_u  = $unsigned(value);
	assign mag_in = val_u[VB-1] ? (~val_u + 1'b1) : val_u;

	for (genvar i = 0; i < NDIG; i++) begin : g_adj
		assign adj[4*i +: 4] = (bcd_q[4*i +: 4] >= DIGIT_ADJ_MIN) ?
			(bcd_q[4*i +: 4] + DIGIT_ADJ_ADD) : bcd_q[4*i +: 4];
	end

	assign top_digit = bcd_q[BCD_W-1 -: 4];
	assign out_free  = !out_valid_q || out_ready;
	assign lead_zero = (top_digit == 4'd0) && (dig_cnt_q != DCW'(1));
	assign emit      = out_free &&
		((ctrl.op == OP_DIGIT) || ((ctrl.op == OP_SIGN) && neg_q));

	assign status.out_free    = out_free;
	assign status.negative    = neg_q;
	assign status.bits_left   = (bit_cnt_q != '0);
	assign status.lead_zero   = lead_zero;
	assign status.more_digits = (dig_cnt_q != DCW'(1));

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_LOAD: begin
				if (in_valid) begin
					mag_q     <= mag_in;
					bcd_q     <= '0;
					bit_cnt_q <= BCW'(VB - 1);
					dig_cnt_q <= DCW'(NDIG);
					neg_q     <= val_u[VB-1];
				end
			end
			OP_SHIFT: begin
				mag_q     <= {mag_q[VB-2:0], 1'b0};
				bcd_q     <= {adj[BCD_W-2:0], mag_q[VB-1]};
				bit_cnt_q <= bit_cnt_q - 1'b1;
			end
			OP_SKIP: begin
				if (lead_zero) begin
					bcd_q     <= {bcd_q[BCD_W-5:0], 4'd0};
					dig_cnt_q <= dig_cnt_q - 1'b1;
				end
			end
			OP_DIGIT: begin
				if (out_free) begin
					bcd_q     <= {bcd_q[BCD_W-5:0], 4'd0};
					dig_cnt_q <= dig_cnt_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			char_code_q <= (ctrl.op == OP_SIGN) ? CHAR_MINUS : (CHAR_ZERO + {4'd0, top_digit});
			last_q      <= (ctrl.op == OP_DIGIT) && (dig_cnt_q == DCW'(1));
		end
	end

	assign out_valid = out_valid_q;
	assign char_code = char_code_q;
	assign last      = last_q;

	`SITDA_ASSERT_IMPLY(a_digit_count_live, ctrl.op == OP_DIGIT, dig_cnt_q != '0, "Digit step with no digits left.")
	`SITDA_ASSERT_IMPLY(a_char_is_digit, out_valid_q && (char_code_q != CHAR_MINUS), (char_code_q >= CHAR_ZERO) && (char_code_q <= CHAR_NINE), "Output character is not a decimal digit.")
	`SITDA_ASSERT_IMPLY(a_minus_not_last, out_valid_q && (char_code_q == CHAR_MINUS), !last_q, "Minus sign marked as the last character.")
	`SITDA_ASSERT_NEXT(a_load_sets_bits, (ctrl.op == OP_LOAD) && in_valid, bit_cnt_q == BCW'(VB - 1), "Bit counter not loaded on input transfer.")

endmodule

>>> src/signed_int_to_decimal_ascii.sv
// Top level of the signed integer to decimal ASCII converter.
// Instantiates sitda_ucode_rom, sitda_sequencer and sitda_datapath; uses sitda_pkg.
//
//  Channel | Signals                        | Direction
//  --------+--------------------------------+----------
//  input   | in_valid, in_ready, value      | in
//  output  | out_valid, out_ready, char_code, last | out
//
// With no stall, an item's program runs the same length whatever the number of digits.
// The microcode program is one load, one double-dabble step per input bit, one skip per
// leading zero and one step past them, a sign step, one step per emitted digit and a return.
// A held output register stretches the program by the stalled cycles.
// Reset clears the step counter and the output valid flag; nothing else needs it.
module signed_int_to_decimal_ascii #(
	parameter int VALUE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [VALUE_BITS-1:0]  value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [7:0]                    char_code,
	output logic                          last
);
	import sitda_pkg::*;

	step_t      step;
	ctrl_word_t ctrl;
	status_t    status;

	sitda_ucode_rom u_rom (
		.step (step),
		.ctrl (ctrl)
	);

	sitda_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.ctrl     (ctrl),
		.status   (status),
		.step     (step)
	);

	sitda_datapath #(
		.VB (VALUE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.in_valid  (in_valid),
		.value     (value),
		.out_ready (out_ready),
		.status    (status),
		.out_valid (out_valid),
		.char_code (char_code),
		.last      (last)
	);

	assign in_ready = (ctrl.op == OP_LOAD);

endmodule
